>>> rtl/core/tlvd_pkg.sv
// shared types, codes and character helpers for the tlv message deframer
`timescale 1ns / 1ps
package tlvd_pkg;

	localparam int BYTE_W   = 8;
	localparam int TYPE_W   = 32;
	localparam int COUNT_W  = 3;
	localparam int LENGTH_W = 16;
	localparam int KIND_W   = 2;
	localparam int HDR_LEN  = 8;
	localparam int HDR_CNT_W = 3;
	localparam int FIELD_LEN = 4;

	localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [TYPE_W-1:0]   type_chars;
		logic [COUNT_W-1:0]  type_count;
		logic [LENGTH_W-1:0] payload_length;
		logic [BYTE_W-1:0]   payload_byte;
		logic                last;
	} result_t;

	// tab, line feed, vertical tab, form feed, carriage return and space
	function automatic logic is_blank(input logic [BYTE_W-1:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_hex(input logic [BYTE_W-1:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

	// index of first non-blank char, 4 when all blank; bit 0 is the first char
	function automatic logic [COUNT_W-1:0] trim_first(input logic [FIELD_LEN-1:0] blk);
		logic [COUNT_W-1:0] s;
		logic               found;
		s = COUNT_W'(FIELD_LEN);
		found = 1'b0;
		for (int i = 0; i < FIELD_LEN; i++) begin
			if (!found && !blk[i]) begin
				s = COUNT_W'(i);
				found = 1'b1;
			end
		end
		return s;
	endfunction

	// one past the last non-blank char, 0 when all blank
	function automatic logic [COUNT_W-1:0] trim_end(input logic [FIELD_LEN-1:0] blk);
		logic [COUNT_W-1:0] e;
		e = '0;
		for (int i = 0; i < FIELD_LEN; i++) begin
			if (!blk[i]) begin
				e = COUNT_W'(i + 1);
			end
		end
		return e;
	endfunction

endpackage

>>> rtl/core/tlvd_in_if.sv
// input channel: framed stream bytes with flush
`timescale 1ns / 1ps
interface tlvd_in_if;
	import tlvd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              flush;

	modport source (output valid, data_byte, flush, input ready);
	modport sink (input valid, data_byte, flush, output ready);
endinterface

>>> rtl/core/tlvd_out_if.sv
// output channel: header, payload and error results
`timescale 1ns / 1ps
interface tlvd_out_if;
	import tlvd_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [TYPE_W-1:0]   type_chars;
	logic [COUNT_W-1:0]  type_count;
	logic [LENGTH_W-1:0] payload_length;
	logic [BYTE_W-1:0]   payload_byte;
	logic                last;

	modport source (output valid, kind, type_chars, type_count, payload_length,
		payload_byte, last, input ready);
	modport sink (input valid, kind, type_chars, type_count, payload_length,
		payload_byte, last, output ready);
endinterface

>>> rtl/core/text_tlv_message_deframer_core.sv
// Deframer for a text stream of messages with a 4-char type and 4-hex-digit length header.
// Takes one byte per cycle on din and gives at most one result per byte on dout, as a
// registered result. Each message starts with an 8-byte header: a type
// and a hex length, both trimmed of ASCII whitespace at both ends. A good header gives a
// header result (kind 0) with the left-aligned type and the length, and the payload
// bytes follow as kind 1 results with last on the final one; a zero length header is
// itself marked last. An all-blank type drops the header with no result, and an empty or
// non-hex length gives an error result (kind 2, last set). flush clears all state and
// gives no result. The whole header check is done in the cycle of the eighth byte,
// between the state registers and the result register; a two-entry output buffer keeps
// din.ready independent of dout.ready, so din is only held off while both entries wait.
`timescale 1ns / 1ps
module text_tlv_message_deframer_core (
	input  logic       clk,
	input  logic       arst_n,
	tlvd_in_if.sink    din,
	tlvd_out_if.source dout
);
	import tlvd_pkg::*;

	logic                          in_payload_q;
	logic [HDR_CNT_W-1:0]          hdr_cnt_q;
	logic [(HDR_LEN-1)*BYTE_W-1:0] hdr_q;
	logic [LENGTH_W-1:0]           remain_q;

	result_t out_s1;
	logic    out_vld_s1;
	result_t skid_q;
	logic    skid_vld_q;

	logic                   acc;
	logic                   pop;
	logic [HDR_LEN*BYTE_W-1:0] full;
	logic [TYPE_W-1:0]      type_word;
	logic [FIELD_LEN-1:0]   type_blk;
	logic [FIELD_LEN-1:0]   len_blk;
	logic [FIELD_LEN-1:0]   len_hex;
	logic [FIELD_LEN-1:0]   len_in_span;
	logic [LENGTH_W-1:0]    len_digits;
	logic [COUNT_W-1:0]     ts, te, ls, le;
	logic [COUNT_W-1:0]     tcount;
	logic [TYPE_W-1:0]      tchars;
	logic [LENGTH_W-1:0]    len_val;
	logic                   len_ok;
	logic [LENGTH_W-1:0]    remain_dec;

	result_t res;
	logic    res_vld;

	assign acc = din.valid && din.ready;
	assign pop = out_vld_s1 && dout.ready;
	assign din.ready = !skid_vld_q;

	// header analysis on the seven stored bytes and the current one
	assign full = {hdr_q, din.data_byte};
	assign type_word = full[HDR_LEN*BYTE_W-1 -: TYPE_W];

	always_comb begin
		for (int i = 0; i < FIELD_LEN; i++) begin
			type_blk[i] = is_blank(full[HDR_LEN*BYTE_W-1-i*BYTE_W -: BYTE_W]);
			len_blk[i]  = is_blank(full[FIELD_LEN*BYTE_W-1-i*BYTE_W -: BYTE_W]);
			len_hex[i]  = is_hex(full[FIELD_LEN*BYTE_W-1-i*BYTE_W -: BYTE_W]);
		end
	end

	assign ts = trim_first(type_blk);
	assign te = trim_end(type_blk);
	assign ls = trim_first(len_blk);
	assign le = trim_end(len_blk);
	assign tcount = te - ts;

	// left-align the type, then keep only tcount chars
	assign tchars = (type_word << {ts, 3'b000}) & (~(TYPE_W'(0)) << {3'd4 - tcount, 3'b000});

	always_comb begin
		len_ok = (ls < le);
		for (int i = 0; i < FIELD_LEN; i++) begin
			len_in_span[i] = (COUNT_W'(i) >= ls) && (COUNT_W'(i) < le);
			len_digits[LENGTH_W-1-i*4 -: 4] = len_in_span[i] ?
				hex_val(full[FIELD_LEN*BYTE_W-1-i*BYTE_W -: BYTE_W]) : 4'd0;
			if (len_in_span[i] && !len_hex[i]) begin
				len_ok = 1'b0;
			end
		end
	end

	// digits before the span are zero, so only the trailing blanks shift out
	assign len_val = len_digits >> {3'd4 - le, 2'b00};
	assign remain_dec = remain_q - LENGTH_W'(1);

	always_comb begin
		res = '0;
		res_vld = 1'b0;
		if (din.flush) begin
			res_vld = 1'b0;
		end else if (in_payload_q) begin
			res_vld = 1'b1;
			res.kind = KIND_PAYLOAD;
			res.payload_byte = din.data_byte;
			res.last = (remain_dec == '0);
		end else if (hdr_cnt_q == HDR_CNT_W'(HDR_LEN - 1) && ts < te) begin
			res_vld = 1'b1;
			res.type_chars = tchars;
			res.type_count = tcount;
			res.last = 1'b1;
			if (!len_ok) begin
				res.kind = KIND_ERROR;
			end else begin
				res.kind = KIND_HEADER;
				res.payload_length = len_val;
				res.last = (len_val == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			hdr_cnt_q <= '0;
			hdr_q <= '0;
			remain_q <= '0;
		end else if (acc) begin
			if (din.flush) begin
				in_payload_q <= 1'b0;
				hdr_cnt_q <= '0;
				hdr_q <= '0;
				remain_q <= '0;
			end else if (in_payload_q) begin
				remain_q <= remain_dec;
				if (remain_dec == '0) begin
					in_payload_q <= 1'b0;
				end
			end else if (hdr_cnt_q != HDR_CNT_W'(HDR_LEN - 1)) begin
				hdr_q <= {hdr_q[(HDR_LEN-2)*BYTE_W-1:0], din.data_byte};
				hdr_cnt_q <= hdr_cnt_q + HDR_CNT_W'(1);
			end else begin
				hdr_q <= '0;
				hdr_cnt_q <= '0;
				if (ts < te && len_ok && len_val != '0) begin
					in_payload_q <= 1'b1;
					remain_q <= len_val;
				end
			end
		end
	end

	// result register with a skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s1 <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_s1 || pop) begin
				if (skid_vld_q) begin
					out_vld_s1 <= 1'b1;
					skid_vld_q <= 1'b0;
				end else begin
					out_vld_s1 <= acc && res_vld;
				end
			end else if (acc && res_vld) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_s1 || pop) begin
			if (skid_vld_q) begin
				out_s1 <= skid_q;
			end else if (acc && res_vld) begin
				out_s1 <= res;
			end
		end else if (acc && res_vld) begin
			skid_q <= res;
		end
	end

	assign dout.valid = out_vld_s1;
	assign dout.kind = out_s1.kind;
	assign dout.type_chars = out_s1.type_chars;
	assign dout.type_count = out_s1.type_count;
	assign dout.payload_length = out_s1.payload_length;
	assign dout.payload_byte = out_s1.payload_byte;
	assign dout.last = out_s1.last;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_s1)
		else $error("skid entry held while result register empty");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (remain_q != '0) && (hdr_cnt_q == '0))
		else $error("payload state with zero count or partial header");

	a_payload_end: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !din.flush && in_payload_q && remain_q == LENGTH_W'(1) |=>
			!in_payload_q && out_vld_s1)
		else $error("final payload byte did not end the message");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && din.flush |=> !in_payload_q && hdr_cnt_q == '0)
		else $error("flush left deframer state behind");
endmodule

>>> sim/text_tlv_message_deframer_core_test.sv
// self-checking testbench for the text tlv message deframer core
`timescale 1ns / 1ps
module text_tlv_message_deframer_core_test;
	import tlvd_pkg::*;

	localparam int HOLD_CYCLES    = 60;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASE_ITEMS    = 440;

	typedef struct packed {
		logic              flush;
		logic [BYTE_W-1:0] data;
	} stream_req_t;

	logic clk;
	logic arst_n;

	tlvd_in_if  din ();
	tlvd_out_if dout ();

	text_tlv_message_deframer_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din),
		.dout  (dout)
	);

	stream_req_t stream_bytes[$];
	result_t     predicted_results[$];
	stream_req_t offer;
	result_t     got_want;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;
	int queued_total = 0;
	int idle_cycles = 0;
	int mismatches = 0;

	int requests_taken = 0;
	int headers_ok = 0;
	int payload_results = 0;
	int bad_headers = 0;
	int blank_drops = 0;
	int flushes = 0;

	// deframer state as predicted
	logic                in_body = 1'b0;
	logic [2:0]          hdr_fill = '0;
	logic [55:0]         hdr_store = '0;
	logic [LENGTH_W-1:0] body_left = '0;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	// trimmed span [s, e) of a four-char field, first char in the top byte
	function automatic void span_of(input logic [31:0] fld, output int s, output int e);
		s = 0;
		e = FIELD_LEN;
		while (s < e && is_space(fld[31-8*s -: 8])) s++;
		while (e > s && is_space(fld[31-8*(e-1) -: 8])) e--;
	endfunction

	task automatic deframe_byte(input logic [7:0] b, input logic fl);
		logic [63:0]         full;
		logic [15:0]         len;
		logic                ok;
		int                  s, e, n, v;
		result_t             r;
		r = '0;
		n = 0;
		len = '0;
		if (fl) begin
			in_body = 1'b0;
			hdr_fill = '0;
			hdr_store = '0;
			body_left = '0;
			flushes++;
			return;
		end
		if (in_body) begin
			body_left = body_left - 1'b1;
			r.kind = KIND_PAYLOAD;
			r.payload_byte = b;
			r.last = (body_left == 0);
			if (r.last) in_body = 1'b0;
			predicted_results.push_back(r);
			payload_results++;
			return;
		end
		if (hdr_fill < 3'd7) begin
			hdr_store = {hdr_store[47:0], b};
			hdr_fill = hdr_fill + 1'b1;
			return;
		end
		full = {hdr_store, b};
		hdr_store = '0;
		hdr_fill = '0;
		span_of(full[63:32], s, e);
		// all-blank type drops the header before the length is looked at
		if (s == e) begin
			blank_drops++;
			return;
		end
		for (int i = s; i < e; i++) begin
			r.type_chars[31-8*n -: 8] = full[63-8*i -: 8];
			n++;
		end
		r.type_count = n[COUNT_W-1:0];
		span_of(full[31:0], s, e);
		ok = (s < e);
		for (int i = s; i < e && ok; i++) begin
			v = hex_digit(full[31-8*i -: 8]);
			if (v < 0) ok = 1'b0;
			else len = {len[11:0], v[3:0]};
		end
		if (!ok) begin
			r.kind = KIND_ERROR;
			r.last = 1'b1;
			bad_headers++;
		end else begin
			r.kind = KIND_HEADER;
			r.payload_length = len;
			r.last = (len == 0);
			if (len != 0) begin
				in_body = 1'b1;
				body_left = len;
			end
			headers_ok++;
		end
		predicted_results.push_back(r);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// stimulus building
	function automatic logic [7:0] blank_char();
		int r;
		r = $urandom_range(5);
		return (r == 5) ? 8'h20 : 8'(8'h09 + r);
	endfunction

	function automatic logic [7:0] letter_char();
		return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] hex_glyph(input logic [3:0] v);
		if (v < 4'd10) return 8'h30 + v;
		return ($urandom_range(1) ? 8'h61 : 8'h41) + v - 8'd10;
	endfunction

	function automatic logic [31:0] blank_field();
		logic [31:0] f;
		for (int i = 0; i < FIELD_LEN; i++) f[31-8*i -: 8] = blank_char();
		return f;
	endfunction

	// never all blank: one position is forced to a letter
	function automatic logic [31:0] type_field();
		logic [31:0] f;
		int          r, k;
		for (int i = 0; i < FIELD_LEN; i++) begin
			r = $urandom_range(9);
			if (r < 6) f[31-8*i -: 8] = letter_char();
			else if (r < 8) f[31-8*i -: 8] = blank_char();
			else f[31-8*i -: 8] = 8'($urandom);
		end
		k = $urandom_range(3);
		f[31-8*k -: 8] = letter_char();
		return f;
	endfunction

	// hex length with leading zeros and blank padding on either side
	function automatic logic [31:0] length_field(input int value);
		logic [31:0] f;
		int          need, digits, lead, k;
		need = (value < 16) ? 1 : (value < 256) ? 2 : 3;
		digits = $urandom_range(4, need);
		lead = $urandom_range(4 - digits);
		for (int i = 0; i < FIELD_LEN; i++) begin
			if (i < lead || i >= lead + digits) begin
				f[31-8*i -: 8] = blank_char();
			end else begin
				k = digits - 1 - (i - lead);
				f[31-8*i -: 8] = hex_glyph(4'((value >> (4 * k)) & 15));
			end
		end
		return f;
	endfunction

	function automatic logic [7:0] odd_char();
		logic [7:0] c;
		do c = 8'($urandom); while (is_space(c) || hex_digit(c) >= 0);
		return c;
	endfunction

	function automatic logic [31:0] bad_length_field();
		logic [31:0] f;
		int          k;
		case ($urandom_range(4))
			0: f = blank_field();
			1: f = {"0", ($urandom_range(1) ? "x" : "X"), hex_glyph(4'($urandom)), blank_char()};
			2: f = {($urandom_range(1) ? "-" : "+"), hex_glyph(4'($urandom)),
				hex_glyph(4'($urandom)), hex_glyph(4'($urandom))};
			3: f = {hex_glyph(4'($urandom)), blank_char(), hex_glyph(4'($urandom)),
				hex_glyph(4'($urandom))};
			default: begin
				f = length_field($urandom_range(15, 1));
				k = $urandom_range(3);
				f[31-8*k -: 8] = odd_char();
			end
		endcase
		return f;
	endfunction

	function automatic int body_size();
		int r;
		r = $urandom_range(99);
		if (r < 10) return 0;
		if (r < 85) return $urandom_range(12, 1);
		if (r < 97) return $urandom_range(40, 13);
		return $urandom_range(300, 41);
	endfunction

	task automatic push_data(input logic [7:0] b);
		stream_bytes.push_back('{flush: 1'b0, data: b});
		queued_total++;
	endtask

	task automatic push_flush();
		stream_bytes.push_back('{flush: 1'b1, data: 8'($urandom)});
		queued_total++;
	endtask

	task automatic push_header(input logic [31:0] t, input logic [31:0] l);
		for (int i = 0; i < FIELD_LEN; i++) push_data(t[31-8*i -: 8]);
		for (int i = 0; i < FIELD_LEN; i++) push_data(l[31-8*i -: 8]);
	endtask

	task automatic push_body(input int n);
		for (int i = 0; i < n; i++) push_data(8'($urandom));
	endtask

	task automatic wait_drained();
		while (!(stream_bytes.size() == 0 && !din.valid && predicted_results.size() == 0))
			@(negedge clk);
	endtask

	task automatic run_phase(input int tx, input int rx, input logic squeeze);
		int start, sel, v;
		tx_idle_pct = tx;
		rx_idle_pct = rx;
		start = queued_total;
		if (squeeze) holds_asked++;
		while (queued_total - start < PHASE_ITEMS) begin
			sel = $urandom_range(99);
			if (sel < 72) begin
				v = body_size();
				push_header(type_field(), length_field(v));
				push_body(v);
			end else if (sel < 82) begin
				push_header(type_field(), bad_length_field());
			end else if (sel < 87) begin
				push_header(blank_field(),
					$urandom_range(1) ? length_field(body_size()) : bad_length_field());
			end else if (sel < 92) begin
				// header cut short
				push_body($urandom_range(7, 1));
				push_flush();
			end else if (sel < 97) begin
				// message abandoned in its payload
				v = $urandom_range(40, 2);
				push_header(type_field(), length_field(v));
				push_body($urandom_range(v - 1, 1));
				push_flush();
			end else begin
				push_body($urandom_range(10));
				push_flush();
			end
		end
		wait_drained();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		din.valid = 1'b0;
		din.data_byte = '0;
		din.flush = 1'b0;
		dout.ready = 1'b0;
		forever #6 clk = ~clk;
	end

	// sender side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din.valid <= 1'b0;
			din.data_byte <= '0;
			din.flush <= 1'b0;
		end else begin
			if (din.valid && din.ready) begin
				deframe_byte(din.data_byte, din.flush);
				requests_taken++;
			end
			if (!din.valid || din.ready) begin
				if (stream_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					offer = stream_bytes.pop_front();
					din.valid <= 1'b1;
					din.data_byte <= offer.data;
					din.flush <= offer.flush;
				end else begin
					din.valid <= 1'b0;
				end
			end
		end
	end

	// receiver side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (dout.valid && dout.ready) begin
				if (predicted_results.size() == 0) begin
					$error("result kind %0d with nothing predicted", dout.kind);
					mismatches++;
				end else begin
					got_want = predicted_results.pop_front();
					compare_field("kind", 32'(got_want.kind), 32'(dout.kind));
					compare_field("type_chars", got_want.type_chars, dout.type_chars);
					compare_field("type_count", 32'(got_want.type_count), 32'(dout.type_count));
					compare_field("payload_length", 32'(got_want.payload_length),
						32'(dout.payload_length));
					compare_field("payload_byte", 32'(got_want.payload_byte),
						32'(dout.payload_byte));
					compare_field("last", 32'(got_want.last), 32'(dout.last));
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				dout.ready <= 1'b0;
			end else if (holds_served != holds_asked) begin
				// long back-pressure so the output buffer fills and din stalls
				holds_served++;
				hold_left = HOLD_CYCLES;
				dout.ready <= 1'b0;
			end else begin
				dout.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((din.valid && din.ready) || (dout.valid && dout.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle_pct = 13;
		rx_idle_pct = 82;
		// trims on both sides, interior blank kept, payload extremes
		push_header({8'h09, "A B"}, "  2 ");
		push_data(8'h00);
		push_data(8'hFF);
		// all-blank type, length never looked at
		push_header({8'h20, 8'h0A, 8'h0D, 8'h0B}, "zz-1");
		// hex prefix in the length
		push_header({"ER", 8'h0C, 8'h20}, "0x1 ");
		// zero length header closes the message itself
		push_header("Z000", "0000");
		// flush in the middle of a long payload
		push_header("LONG", "F000");
		push_data(8'h5A);
		push_flush();
		wait_drained();

		run_phase(13, 82, 1'b1);
		run_phase(82, 13, 1'b0);
		run_phase(0, 0, 1'b1);

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered %0d requests: %0d good headers, %0d payload bytes, %0d bad lengths",
			requests_taken, headers_ok, payload_results, bad_headers);
		$display("  %0d blank types dropped, %0d flushes, %0d long receiver holds",
			blank_drops, flushes, holds_served);
		if (mismatches == 0 && predicted_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
